>>> design/eclb_pkg.sv
// ----------------------------------------------------------------------------
// eclb_pkg: shared types and constants for the error code LED blinker
// Request/result payloads, blink timing registers, command codes and
// register addresses.
// ----------------------------------------------------------------------------
`default_nettype none

package eclb_pkg;

   // Request and result payloads
   typedef struct packed {
      logic       command;
      logic [7:0] new_code;
   } req_type;

   typedef struct packed {
      logic       led_on;
      logic [7:0] current_code;
   } rsp_type;

   // Timing registers as seen by the blink machine
   typedef struct packed {
      logic [7:0] tick_divisor;
      logic [7:0] on_periods;
      logic [7:0] off_periods;
      logic [7:0] pause_periods;
   } cfg_type;

   // Register reset values
   localparam logic [7:0] TICK_DIVISOR_RST  = 8'd164;
   localparam logic [7:0] ON_PERIODS_RST    = 8'd18;
   localparam logic [7:0] OFF_PERIODS_RST   = 8'd18;
   localparam logic [7:0] PAUSE_PERIODS_RST = 8'd80;

   // Register indexes (word address)
   localparam int unsigned          REG_IDX_W         = 2;
   localparam logic [REG_IDX_W-1:0] REG_TICK_DIVISOR  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ON_PERIODS    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_OFF_PERIODS   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_PAUSE_PERIODS = 2'd3;

   // Request command codes
   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_SET_CODE = 1'b1;

endpackage

`default_nettype wire

>>> design/eclb_core.sv
// ----------------------------------------------------------------------------
// eclb_core: tick divider and blink phase machine
// Holds the blink state and updates it once per accepted request; the
// result is the LED level and code after that update.
// ----------------------------------------------------------------------------
`default_nettype none

module eclb_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire eclb_pkg::req_type req,
   input  wire eclb_pkg::cfg_type cfg,
   output eclb_pkg::rsp_type     result
);
   import eclb_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ON    = 2'd1;
   localparam logic [1:0] PH_OFF   = 2'd2;
   localparam logic [1:0] PH_PAUSE = 2'd3;

   logic [7:0] divider_count_ff, divider_count_in;
   logic [7:0] periods_left_ff,  periods_left_in;
   logic [7:0] flashes_done_ff,  flashes_done_in;
   logic [1:0] phase_ff,         phase_in;
   logic [7:0] code_ff,          code_in;
   logic       led_ff,           led_in;

   logic [8:0] div_next;

   assign div_next = {1'b0, divider_count_ff} + 9'd1;

   // Next state for one request
   always_comb begin
      divider_count_in = divider_count_ff;
      periods_left_in  = periods_left_ff;
      flashes_done_in  = flashes_done_ff;
      phase_in         = phase_ff;
      code_in          = code_ff;
      led_in           = led_ff;
      if (req.command == CMD_SET_CODE) begin
         if (req.new_code == 8'd0) begin
            phase_in = PH_IDLE;
            led_in   = 1'b0;
         end else if (req.new_code != code_ff) begin
            phase_in = PH_OFF;
         end
         code_in = req.new_code;
      end else if (div_next < {1'b0, cfg.tick_divisor}) begin
         divider_count_in = div_next[7:0];
      end else begin
         divider_count_in = 8'd0;
         // Machine step: count down, or move to the next phase at zero
         if (periods_left_ff != 8'd0) begin
            periods_left_in = periods_left_ff - 8'd1;
         end else begin
            case (phase_ff)
               PH_ON: begin
                  if (flashes_done_ff != 8'hff) begin
                     flashes_done_in = flashes_done_ff + 8'd1;
                  end
                  phase_in        = PH_OFF;
                  periods_left_in = cfg.off_periods;
                  led_in          = 1'b0;
               end
               PH_OFF: begin
                  if (flashes_done_ff >= code_ff) begin
                     phase_in        = PH_PAUSE;
                     periods_left_in = cfg.pause_periods;
                  end else begin
                     phase_in        = PH_ON;
                     periods_left_in = cfg.on_periods;
                     led_in          = 1'b1;
                  end
               end
               PH_PAUSE: begin
                  flashes_done_in = 8'd0;
                  phase_in        = PH_ON;
                  periods_left_in = cfg.on_periods;
                  led_in          = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_count_ff <= 8'd0;
         periods_left_ff  <= 8'd0;
         flashes_done_ff  <= 8'd0;
         phase_ff         <= PH_IDLE;
         code_ff          <= 8'd0;
         led_ff           <= 1'b0;
      end else if (accept) begin
         divider_count_ff <= divider_count_in;
         periods_left_ff  <= periods_left_in;
         flashes_done_ff  <= flashes_done_in;
         phase_ff         <= phase_in;
         code_ff          <= code_in;
         led_ff           <= led_in;
      end
   end

   assign result.led_on       = led_in;
   assign result.current_code = code_in;

endmodule

`default_nettype wire

>>> design/error_code_led_blinker.sv
// Each result is registered in the result register, or in the skid slot.
// Throughput: one request per cycle unless stalled; single-pass update.
// A two-entry result buffer keeps requests flowing while a result is stalled.
// Synchronous active-high reset clears the blink state to idle, LED off,
// code zero, and loads the timing registers with their default values.
// ----------------------------------------------------------------------------
// error_code_led_blinker: debug LED error code blinker
// Timing register port, blink core, and registered result with skid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module error_code_led_blinker (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire eclb_pkg::req_type req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output eclb_pkg::rsp_type      rsp_data,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import eclb_pkg::*;

   cfg_type             cfg_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                cfg_write;

   logic    accept;
   rsp_type core_result;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    out_taken;

   // Register port
   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_divisor  <= TICK_DIVISOR_RST;
         cfg_ff.on_periods    <= ON_PERIODS_RST;
         cfg_ff.off_periods   <= OFF_PERIODS_RST;
         cfg_ff.pause_periods <= PAUSE_PERIODS_RST;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_TICK_DIVISOR:  cfg_ff.tick_divisor  <= pwdata[7:0];
            REG_ON_PERIODS:    cfg_ff.on_periods    <= pwdata[7:0];
            REG_OFF_PERIODS:   cfg_ff.off_periods   <= pwdata[7:0];
            REG_PAUSE_PERIODS: cfg_ff.pause_periods <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TICK_DIVISOR:  prdata = {24'd0, cfg_ff.tick_divisor};
         REG_ON_PERIODS:    prdata = {24'd0, cfg_ff.on_periods};
         REG_OFF_PERIODS:   prdata = {24'd0, cfg_ff.off_periods};
         REG_PAUSE_PERIODS: prdata = {24'd0, cfg_ff.pause_periods};
         default:           prdata = 32'd0;
      endcase
   end

   // Request accept: stall only while the skid slot is occupied
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;

   eclb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // Result register plus skid slot
   assign out_taken = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_taken) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_ff || (out_taken && !skid_valid_ff)) begin
            out_in       = core_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = core_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
